// ----- sv/gpcs_pkg.sv -----
// ----------------------------------------------------------------------------
// gpcs_pkg
// Shared types and constants for the gait phase and contact scheduler.
// ----------------------------------------------------------------------------
package gpcs_pkg;

  localparam int TIME_BITS  = 23;
  localparam int DT_BITS    = 16;
  localparam int CFG_T_BITS = 22;
  localparam int RECIP_BITS = 32;
  localparam int Q15_BITS   = 16;
  localparam int MUL_BITS   = TIME_BITS + 2;
  localparam int PROD_BITS  = MUL_BITS + RECIP_BITS;
  localparam int APB_AW     = 4;
  localparam int APB_DW     = 32;

  localparam logic [7:0] START_CODE = 8'd4;

  localparam logic [1:0] PH_STAND = 2'd0;
  localparam logic [1:0] PH_TRANS = 2'd1;
  localparam logic [1:0] PH_STEP  = 2'd2;

  localparam logic [Q15_BITS-1:0] Q15_ONE  = 16'h8000;
  localparam logic [Q15_BITS-1:0] Q15_HALF = 16'h4000;

  localparam logic [1:0] REG_STEP_TIME = 2'd0;
  localparam logic [1:0] REG_DS_TIME   = 2'd1;
  localparam logic [1:0] REG_DS_RECIP  = 2'd2;

  typedef logic [1:0] wmode_t;
  localparam wmode_t WM_FULL  = 2'd0;
  localparam wmode_t WM_FLAT  = 2'd1;
  localparam wmode_t WM_EARLY = 2'd2;
  localparam wmode_t WM_LATE  = 2'd3;

  typedef struct packed {
    logic [7:0]         command;
    logic [DT_BITS-1:0] dt_us;
  } in_t;

  typedef struct packed {
    logic [1:0]          phase;
    logic                stance_first;
    logic [Q15_BITS-1:0] contact_first;
    logic [Q15_BITS-1:0] contact_second;
    logic [TIME_BITS-1:0] step_time_now;
  } out_t;

  typedef struct packed {
    logic [CFG_T_BITS-1:0] step_time_us;
    logic [CFG_T_BITS-1:0] ds_time_us;
    logic [RECIP_BITS-1:0] ds_recip;
  } cfg_t;

  typedef struct packed {
    logic [1:0]           phase;
    logic                 stance;
    logic [TIME_BITS-1:0] t;
    wmode_t               mode;
    logic                 shift17;
    logic [MUL_BITS-1:0]  operand;
  } ctx_t;

endpackage

// ----- sv/gpcs_cfg.sv -----
// ----------------------------------------------------------------------------
// gpcs_cfg
// APB register file: step time, double-support time and its reciprocal.
// ----------------------------------------------------------------------------
module gpcs_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [gpcs_pkg::APB_AW-1:0] paddr,
  input  logic [gpcs_pkg::APB_DW-1:0] pwdata,
  output logic [gpcs_pkg::APB_DW-1:0] prdata,
  output logic                        pready,
  output gpcs_pkg::cfg_t              cfg
);
  import gpcs_pkg::*;

  cfg_t       cfg_r;
  cfg_t       cfg_nxt;
  logic [1:0] idx;
  logic       wr_en;

  assign idx    = paddr[APB_AW-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_STEP_TIME: cfg_nxt.step_time_us = pwdata[CFG_T_BITS-1:0];
        REG_DS_TIME:   cfg_nxt.ds_time_us   = pwdata[CFG_T_BITS-1:0];
        REG_DS_RECIP:  cfg_nxt.ds_recip     = pwdata[RECIP_BITS-1:0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_STEP_TIME: prdata = APB_DW'(cfg_r.step_time_us);
      REG_DS_TIME:   prdata = APB_DW'(cfg_r.ds_time_us);
      REG_DS_RECIP:  prdata = APB_DW'(cfg_r.ds_recip);
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.step_time_us <= CFG_T_BITS'(400000);
      cfg_r.ds_time_us   <= '0;
      cfg_r.ds_recip     <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ----- sv/gpcs_timer.sv -----
// ----------------------------------------------------------------------------
// gpcs_timer
// Step time accumulation, phase sequencing, stance swap and window selection.
// ----------------------------------------------------------------------------
module gpcs_timer (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           advance,
  input  gpcs_pkg::in_t  req,
  input  gpcs_pkg::cfg_t cfg,
  output gpcs_pkg::ctx_t ctx
);
  import gpcs_pkg::*;

  logic [1:0]           phase_r, phase_nxt;
  logic [TIME_BITS-1:0] elapsed_r, elapsed_nxt;
  logic                 stance_r, stance_nxt;

  logic                 run;
  logic [TIME_BITS:0]   sum;
  logic [TIME_BITS-1:0] sat;
  logic                 boundary;
  logic [TIME_BITS:0]   dbl_t;
  logic [MUL_BITS-1:0]  late_sum;
  logic [MUL_BITS-1:0]  dbl_step;
  logic                 in_early;
  logic                 in_late;

  assign run      = (req.command == START_CODE) || (phase_r != PH_STAND);
  assign sum      = {1'b0, elapsed_r} + (TIME_BITS+1)'(req.dt_us);
  assign sat      = sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];
  assign boundary = run && (sat > TIME_BITS'(cfg.step_time_us));

  always_comb begin
    elapsed_nxt = elapsed_r;
    phase_nxt   = phase_r;
    if (run) begin
      elapsed_nxt = boundary ? '0 : sat;
      if (boundary && (phase_r != PH_STEP)) begin
        phase_nxt = phase_r + 2'd1;
      end
    end
    stance_nxt = (phase_nxt == PH_STEP && boundary) ? ~stance_r : stance_r;
  end

  assign dbl_t    = {elapsed_nxt, 1'b0};
  assign late_sum = {1'b0, dbl_t} + MUL_BITS'(cfg.ds_time_us);
  assign dbl_step = MUL_BITS'({cfg.step_time_us, 1'b0});
  assign in_early = dbl_t <= (TIME_BITS+1)'(cfg.ds_time_us);
  assign in_late  = late_sum >= dbl_step;

  always_comb begin
    ctx.phase   = phase_nxt;
    ctx.stance  = stance_nxt;
    ctx.t       = elapsed_nxt;
    ctx.shift17 = 1'b0;
    ctx.operand = '0;
    if (phase_nxt != PH_STEP) begin
      ctx.mode = WM_FULL;
    end else if (cfg.ds_time_us == '0) begin
      ctx.mode = WM_FLAT;
    end else if (in_early) begin
      ctx.mode    = WM_EARLY;
      ctx.operand = MUL_BITS'(elapsed_nxt);
    end else if (in_late) begin
      ctx.mode    = WM_LATE;
      ctx.shift17 = 1'b1;
      ctx.operand = late_sum - dbl_step;
    end else begin
      ctx.mode = WM_FLAT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_STAND;
      elapsed_r <= '0;
      stance_r  <= 1'b1;
    end else if (advance) begin
      phase_r   <= phase_nxt;
      elapsed_r <= elapsed_nxt;
      stance_r  <= stance_nxt;
    end
  end

endmodule

// ----- sv/gpcs_weight.sv -----
// ----------------------------------------------------------------------------
// gpcs_weight
// Contact weight ramp: reciprocal multiply, saturation and leg assignment.
// ----------------------------------------------------------------------------
module gpcs_weight (
  input  gpcs_pkg::ctx_t                  ctx,
  input  logic [gpcs_pkg::RECIP_BITS-1:0] ds_recip,
  output gpcs_pkg::out_t                  res
);
  import gpcs_pkg::*;

  logic [PROD_BITS-1:0] prod;
  logic [PROD_BITS-1:0] r_raw;
  logic [Q15_BITS-1:0]  r;
  logic [Q15_BITS-1:0]  swing;
  logic [Q15_BITS-1:0]  stance;

  assign prod  = PROD_BITS'(ctx.operand) * PROD_BITS'(ds_recip);
  assign r_raw = ctx.shift17 ? (prod >> 17) : (prod >> 16);
  assign r     = (r_raw > PROD_BITS'(Q15_ONE)) ? Q15_ONE : r_raw[Q15_BITS-1:0];

  always_comb begin
    unique case (ctx.mode)
      WM_FULL: begin
        swing  = Q15_ONE;
        stance = Q15_ONE;
      end
      WM_FLAT: begin
        swing  = '0;
        stance = Q15_ONE;
      end
      WM_EARLY: begin
        swing  = (r >= Q15_HALF) ? '0 : (Q15_HALF - r);
        stance = (r >= Q15_HALF) ? Q15_ONE : (Q15_HALF + r);
      end
      WM_LATE: begin
        swing  = r;
        stance = Q15_ONE - r;
      end
      default: begin
        swing  = '0;
        stance = Q15_ONE;
      end
    endcase
  end

  always_comb begin
    res.phase          = ctx.phase;
    res.stance_first   = ctx.stance;
    res.step_time_now  = ctx.t;
    res.contact_first  = ctx.stance ? swing : stance;
    res.contact_second = ctx.stance ? stance : swing;
  end

endmodule

// ----- sv/gait_phase_contact_scheduler.sv -----
// ----------------------------------------------------------------------------
// gait_phase_contact_scheduler
// Walking gait phase sequencer with double-support contact weight ramps.
// ----------------------------------------------------------------------------
//   port group | direction | carries
//   in_*       | input     | request: command, dt_us
//   out_*      | output    | phase, stance, two Q1.15 contact weights, step time
//   APB        | slave     | step_time_us, ds_time_us, ds_recip at 0x0/0x4/0x8
//
// One request per cycle while in_stall is low; out_valid rises once the request has passed
// the input, timer and result registers. Stages: input register, timer update (state commits
// here), multiply and result. Synchronous active-low reset returns to standing, time zero, stance +1.
// A stalled result holds; upstream stages keep filling until the pipe is full.
// ----------------------------------------------------------------------------
module gait_phase_contact_scheduler (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  gpcs_pkg::in_t               in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output gpcs_pkg::out_t              out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [gpcs_pkg::APB_AW-1:0] paddr,
  input  logic [gpcs_pkg::APB_DW-1:0] pwdata,
  output logic [gpcs_pkg::APB_DW-1:0] prdata,
  output logic                        pready
);
  import gpcs_pkg::*;

  cfg_t cfg;
  in_t  in_r;
  logic in_v_r;
  ctx_t ctx_nxt, ctx_r;
  logic ctx_v_r;
  out_t res_nxt, out_r;
  logic out_v_r;

  logic out_adv;
  logic ctx_adv;
  logic in_adv;
  logic a_fire;

  gpcs_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign out_adv  = !out_v_r || !out_stall;
  assign ctx_adv  = !ctx_v_r || out_adv;
  assign in_adv   = !in_v_r || ctx_adv;
  assign a_fire   = in_v_r && ctx_adv;
  assign in_stall = !in_adv;

  gpcs_timer u_timer (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (a_fire),
    .req     (in_r),
    .cfg     (cfg),
    .ctx     (ctx_nxt)
  );

  gpcs_weight u_weight (
    .ctx      (ctx_r),
    .ds_recip (cfg.ds_recip),
    .res      (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      ctx_v_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_adv) begin
        in_v_r <= in_valid;
      end
      if (ctx_adv) begin
        ctx_v_r <= in_v_r;
      end
      if (out_adv) begin
        out_v_r <= ctx_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_adv && in_valid) begin
      in_r <= in_data;
    end
    if (a_fire) begin
      ctx_r <= ctx_nxt;
    end
    if (out_adv && ctx_v_r) begin
      out_r <= res_nxt;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

`ifndef NO_ASSERTIONS
  a_full_before_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.phase != PH_STEP) |->
      (out_data.contact_first == Q15_ONE && out_data.contact_second == Q15_ONE))
    else $error("weights not full before stepping");

  a_weights_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.phase == PH_STEP) |->
      (({1'b0, out_data.contact_first} + {1'b0, out_data.contact_second}) == 17'h08000))
    else $error("stepping weights do not sum to one");

  a_ctx_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ctx_v_r && !ctx_adv) |=> ($stable(ctx_r) && ctx_v_r))
    else $error("timer stage changed while blocked");
`endif

endmodule
